// ===== rtl/swlfo_pkg.sv =====
// Shared types, constants and the sine table generator of the sequenced waveform LFO.
package swlfo_pkg;

	// Default values of the top-level parameters.
	localparam int DEF_PHASE_FRAC_BITS  = 22;
	localparam int DEF_SINE_TABLE_DEPTH = 256;

	// Sample and waveform widths (Q1.15 samples, waveform values reach +1.0).
	localparam int SAMPLE_W = 16;
	localparam int WAVE_W   = 17;
	localparam int DEPTH_W  = 16;

	// Configuration port.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM_MASK = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STEREO_INVERT = 1'd1;

	localparam logic signed [WAVE_W-1:0] WAVE_FULL = 17'sd32768;
	localparam logic signed [WAVE_W-1:0] WAVE_ZERO = 17'sd0;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_TRIANGLE = 2'd2,
		WAVE_SAW      = 2'd3
	} wave_kind_t;

	// Which waveform the current phase segment selects.
	typedef struct packed {
		logic       found;
		wave_kind_t kind;
	} wave_sel_t;

	// Division by 16384 that truncates toward zero.
	function automatic longint trunc_q14(input longint x);
		if (x >= 0) begin
			return x >>> 14;
		end
		return -((-x) >>> 14);
	endfunction

	// Value of -sin(2*pi*a/65536) in Q15 units from the polynomial quarter wave.
	function automatic logic signed [WAVE_W-1:0] sine_from_angle(input int angle);
		longint q;
		longint r;
		longint z2;
		longint t;
		longint s;
		q = longint'(angle) >>> 14;
		r = longint'(angle) & 64'sd16383;
		if ((q & 64'sd1) != 0) begin
			r = 64'sd16384 - r;
		end
		z2 = trunc_q14(r * r);
		t  = trunc_q14(64'sd2320 * z2);
		t  = trunc_q14((t - 64'sd21024) * z2);
		s  = trunc_q14((t + 64'sd51472) * r);
		if (s < 0) begin
			s = 0;
		end
		if (s > 64'sd32768) begin
			s = 64'sd32768;
		end
		return (q < 2) ? WAVE_W'(-s) : WAVE_W'(s);
	endfunction

endpackage

// ===== rtl/swlfo_phase.sv =====
// Phase accumulator with single-subtraction wrap and segment to waveform selection.
module swlfo_phase #(
	parameter int PHASE_FRAC_BITS = swlfo_pkg::DEF_PHASE_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [3:0]                   waveform_mask,
	input  logic [PHASE_FRAC_BITS:0]     phase_step,
	input  logic                         load_phase,
	input  logic [PHASE_FRAC_BITS-1:0]   load_value,
	output logic [PHASE_FRAC_BITS-1:0]   frac,
	output swlfo_pkg::wave_sel_t         sel
);

	localparam int F = PHASE_FRAC_BITS;
	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

	logic [F+1:0] phase_q;
	logic [F:0]   step_sat;
	logic [F+1:0] base;
	logic [F+2:0] sum;
	logic [2:0]   count;
	logic [F+2:0] limit;
	logic [F+2:0] wrapped;
	logic [F+1:0] phase_next;
	logic [1:0]   seg;
	logic [1:0]   rank [4];

	assign step_sat = (phase_step > ONE) ? ONE : phase_step;
	assign base     = load_phase ? {2'b00, load_value} : phase_q;
	assign sum      = {1'b0, base} + {2'b00, step_sat};
	assign count    = {2'b00, waveform_mask[0]} + {2'b00, waveform_mask[1]}
		+ {2'b00, waveform_mask[2]} + {2'b00, waveform_mask[3]};
	assign limit    = {count, {F{1'b0}}};
	assign wrapped  = (sum >= limit) ? (sum - limit) : sum;
	assign phase_next = wrapped[F+1:0];

	assign seg  = phase_next[F+1:F];
	assign frac = phase_next[F-1:0];

	// Position of each waveform among the enabled ones.
	assign rank[0] = 2'd0;
	assign rank[1] = {1'b0, waveform_mask[0]};
	assign rank[2] = {1'b0, waveform_mask[0]} + {1'b0, waveform_mask[1]};
	assign rank[3] = {1'b0, waveform_mask[0]} + {1'b0, waveform_mask[1]}
		+ {1'b0, waveform_mask[2]};

	always_comb begin
		sel.found = 1'b0;
		sel.kind  = swlfo_pkg::WAVE_SINE;
		for (int k = 0; k < 4; k++) begin
			if (!sel.found && waveform_mask[k] && (rank[k] == seg)) begin
				sel.found = 1'b1;
				sel.kind  = swlfo_pkg::wave_kind_t'(k[1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (advance && (waveform_mask != 4'd0)) begin
			phase_q <= phase_next;
		end
	end

endmodule

// ===== rtl/swlfo_shape.sv =====
// Waveform generator: sine table, square, triangle and saw from the phase fraction.
module swlfo_shape #(
	parameter int PHASE_FRAC_BITS  = swlfo_pkg::DEF_PHASE_FRAC_BITS,
	parameter int SINE_TABLE_DEPTH = swlfo_pkg::DEF_SINE_TABLE_DEPTH
) (
	input  logic [PHASE_FRAC_BITS-1:0]             frac,
	input  swlfo_pkg::wave_sel_t                   sel,
	output logic signed [swlfo_pkg::WAVE_W-1:0]    wave
);

	localparam int F     = PHASE_FRAC_BITS;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int WW    = swlfo_pkg::WAVE_W;

	localparam logic [F-1:0]        QUARTER = {2'b01, {(F-2){1'b0}}};
	localparam logic signed [F+2:0] ONE_S   = (F+3)'(1) <<< F;
	localparam logic signed [F+2:0] THREE_S = (F+3)'(3) <<< F;

	logic signed [WW-1:0]     sine_tab [SINE_TABLE_DEPTH];
	logic [F+IDX_W-1:0]       idx_prod;
	logic [IDX_W-1:0]         idx;
	logic [F-1:0]             g;
	logic signed [F+2:0]      four_g;
	logic signed [F+2:0]      v_tri;
	logic signed [F+2:0]      v_saw;
	logic signed [F+17:0]     tri_wide;
	logic signed [F+17:0]     saw_wide;
	logic signed [WW-1:0]     w_tri;
	logic signed [WW-1:0]     w_saw;
	logic signed [WW-1:0]     w_sine;
	logic signed [WW-1:0]     w_square;

	for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_sine
		localparam int ANGLE = (i * 65536) / SINE_TABLE_DEPTH;
		assign sine_tab[i] = swlfo_pkg::sine_from_angle(ANGLE);
	end

	assign idx_prod = (F+IDX_W)'(frac) * (F+IDX_W)'(SINE_TABLE_DEPTH);
	assign idx      = idx_prod[F+IDX_W-1:F];
	assign w_sine   = sine_tab[idx];

	assign w_square = frac[F-1] ? swlfo_pkg::WAVE_FULL : -swlfo_pkg::WAVE_FULL;

	// Triangle starts a quarter period early so that it rises through zero.
	assign g      = frac + QUARTER;
	assign four_g = $signed({1'b0, g, 2'b00});
	assign v_tri  = g[F-1] ? (THREE_S - four_g) : (four_g - ONE_S);
	assign v_saw  = $signed({2'b00, frac, 1'b0}) - ONE_S;

	// Rescale to Q15 units, rounding toward minus infinity.
	assign tri_wide = ((F+18)'(v_tri) <<< 15) >>> F;
	assign saw_wide = ((F+18)'(v_saw) <<< 15) >>> F;
	assign w_tri    = tri_wide[WW-1:0];
	assign w_saw    = saw_wide[WW-1:0];

	always_comb begin
		if (!sel.found) begin
			wave = swlfo_pkg::WAVE_ZERO;
		end else begin
			case (sel.kind)
				swlfo_pkg::WAVE_SINE:     wave = w_sine;
				swlfo_pkg::WAVE_SQUARE:   wave = w_square;
				swlfo_pkg::WAVE_TRIANGLE: wave = w_tri;
				swlfo_pkg::WAVE_SAW:      wave = w_saw;
				default:                  wave = swlfo_pkg::WAVE_ZERO;
			endcase
		end
	end

endmodule

// ===== rtl/swlfo_scale.sv =====
// Depth scaling with saturation and the stereo copy, optionally inverted, of the sample.
module swlfo_scale (
	input  logic signed [swlfo_pkg::WAVE_W-1:0]   wave,
	input  logic [swlfo_pkg::DEPTH_W-1:0]         depth_gain,
	input  logic                                  stereo_invert,
	output logic signed [swlfo_pkg::SAMPLE_W-1:0] left_sample,
	output logic signed [swlfo_pkg::SAMPLE_W-1:0] right_sample
);

	localparam int PW = swlfo_pkg::WAVE_W + swlfo_pkg::DEPTH_W + 1;
	localparam logic signed [swlfo_pkg::SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [swlfo_pkg::SAMPLE_W-1:0] S_MIN = 16'sh8000;

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] scaled;

	assign prod   = PW'(wave) * PW'($signed({1'b0, depth_gain}));
	assign scaled = prod >>> 15;

	always_comb begin
		if (scaled > PW'(S_MAX)) begin
			left_sample = S_MAX;
		end else if (scaled < PW'(S_MIN)) begin
			left_sample = S_MIN;
		end else begin
			left_sample = scaled[swlfo_pkg::SAMPLE_W-1:0];
		end
	end

	always_comb begin
		if (!stereo_invert) begin
			right_sample = left_sample;
		end else if (left_sample == S_MIN) begin
			right_sample = S_MAX;
		end else begin
			right_sample = -left_sample;
		end
	end

endmodule

// ===== rtl/sequenced_waveform_lfo_unit.sv =====
// Top level of the sequenced waveform LFO: stream ports, registers and assertions.
// A result passes the input register and then the result register, which drives the output.
// Throughput: one item per cycle unless the output stalls; the loop is the phase add, compare and subtract.
// Input is stalled only while both the input register and the result register are full.
// Reset (arst_n low, asynchronous) clears the phase, the waveform mask, stereo inversion and all valid flags.
// Reset leaves every waveform disabled, so items give silence until the waveform mask is written.
module sequenced_waveform_lfo_unit #(
	parameter int PHASE_FRAC_BITS  = swlfo_pkg::DEF_PHASE_FRAC_BITS,
	parameter int SINE_TABLE_DEPTH = swlfo_pkg::DEF_SINE_TABLE_DEPTH,
	localparam int IN_BITS     = 2 * PHASE_FRAC_BITS + 18,
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_TDATA_W = 2 * swlfo_pkg::SAMPLE_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration writes.
	input  logic                                cfg_we,
	input  logic [swlfo_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [swlfo_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// Sample ticks in.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// From bit 0: phase_step, depth_gain, load_phase, load_value, zero padding.
	input  logic [IN_TDATA_W-1:0]               s_axis_tdata,
	// Samples out.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// From bit 0: left_sample, right_sample.
	output logic [OUT_TDATA_W-1:0]              m_axis_tdata
);

	localparam int F         = PHASE_FRAC_BITS;
	localparam int STEP_LSB  = 0;
	localparam int DEPTH_LSB = F + 1;
	localparam int LOAD_LSB  = F + 17;
	localparam int LVAL_LSB  = F + 18;
	localparam int SW        = swlfo_pkg::SAMPLE_W;

	// Configuration registers.
	logic [3:0] waveform_mask_q;
	logic       stereo_invert_q;

	// Input register.
	logic                            valid_s1;
	logic [F:0]                      step_s1;
	logic [swlfo_pkg::DEPTH_W-1:0]   depth_s1;
	logic                            load_s1;
	logic [F-1:0]                    lval_s1;

	// Result register.
	logic                  valid_s2;
	logic signed [SW-1:0]  left_s2;
	logic signed [SW-1:0]  right_s2;

	logic                                  advance;
	logic                                  in_xfer;
	logic [F-1:0]                          frac;
	swlfo_pkg::wave_sel_t                  sel;
	logic signed [swlfo_pkg::WAVE_W-1:0]   wave;
	logic signed [SW-1:0]                  left_sample;
	logic signed [SW-1:0]                  right_sample;

	// The item in the input register moves on whenever the result register is
	// free or its transfer completes in this cycle; the input side is then open.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_mask_q <= 4'd0;
			stereo_invert_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				swlfo_pkg::REG_WAVEFORM_MASK: waveform_mask_q <= cfg_wdata[3:0];
				swlfo_pkg::REG_STEREO_INVERT: stereo_invert_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			step_s1  <= s_axis_tdata[STEP_LSB +: F + 1];
			depth_s1 <= s_axis_tdata[DEPTH_LSB +: swlfo_pkg::DEPTH_W];
			load_s1  <= s_axis_tdata[LOAD_LSB];
			lval_s1  <= s_axis_tdata[LVAL_LSB +: F];
		end
	end

	// The phase advances with each item that leaves the input register while any waveform is enabled, so
	// consecutive items chain through the accumulator without a bubble.
	swlfo_phase #(
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_phase (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.waveform_mask (waveform_mask_q),
		.phase_step    (step_s1),
		.load_phase    (load_s1),
		.load_value    (lval_s1),
		.frac          (frac),
		.sel           (sel)
	);

	swlfo_shape #(
		.PHASE_FRAC_BITS  (PHASE_FRAC_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_shape (
		.frac (frac),
		.sel  (sel),
		.wave (wave)
	);

	swlfo_scale u_scale (
		.wave          (wave),
		.depth_gain    (depth_s1),
		.stereo_invert (stereo_invert_q),
		.left_sample   (left_sample),
		.right_sample  (right_sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_s2  <= left_sample;
			right_s2 <= right_sample;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {right_s2, left_s2};

	// The input side is only ever held off while both registers are occupied.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2))
		else $error("input stalled while a register stage was free");

	// With every waveform disabled the phase holds still.
	a_phase_frozen_when_muted: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (waveform_mask_q == 4'd0)) |=> $stable(u_phase.phase_q))
		else $error("phase moved with an empty waveform mask");

	// With every waveform disabled the result is silence on both channels.
	a_silence_when_muted: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (waveform_mask_q == 4'd0) && !cfg_we) |=> (m_axis_tdata == '0))
		else $error("non-zero sample with an empty waveform mask");

	// Without stereo inversion both channels carry the same sample.
	a_mono_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !stereo_invert_q) |=> (right_s2 == left_s2))
		else $error("right channel differs from left without inversion");

endmodule
